FILE: rtl/qbed_pkg.sv
// Shared types, constants and the quadrature lookup for the event decoder.
`default_nettype none
package qbed_pkg;

    // Button count scanned per sample, and the physical width of the level port.
    localparam int NUM_BUTTONS = 8;
    localparam int BTN_BITS    = 8;
    localparam int NUM_LANES   = (NUM_BUTTONS < BTN_BITS) ? NUM_BUTTONS : BTN_BITS;

    typedef logic [3:0] event_code_t;

    localparam event_code_t EV_NONE     = 4'd0;
    localparam event_code_t EV_VOL_DOWN = 4'd9;
    localparam event_code_t EV_VOL_UP   = 4'd10;

    // Register select is paddr[2]: one 32-bit register per word address.
    localparam logic REG_STEP_THRESHOLD = 1'b0;
    localparam logic REG_DEBOUNCE_MS    = 1'b1;

    localparam logic [3:0]          STEP_THRESHOLD_RST = 4'd4;
    localparam logic [7:0]          DEBOUNCE_MS_RST    = 8'd20;
    localparam logic [1:0]          PHASE_RST          = 2'b11;
    localparam logic [BTN_BITS-1:0] BUTTONS_RST        = '1;

    typedef logic signed [1:0] quad_delta_t;

    typedef struct packed {
        logic hit;
        logic up;
    } quad_res_t;

    typedef struct packed {
        logic        found;
        event_code_t code;
    } btn_pick_t;

    // Transition {previous pair, new pair} to a signed step.
    function automatic quad_delta_t quad_delta(input logic [3:0] idx);
        quad_delta_t d;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
            default: d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/qbed_quad.sv
// Quadrature step accumulator with threshold detection.
`default_nettype none
module qbed_quad (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [1:0]        phase,
    input  wire logic [3:0]        step_threshold,
    output qbed_pkg::quad_res_t    res
);
    import qbed_pkg::*;

    logic [1:0]        prev_phase_reg;
    logic [1:0]        prev_phase_next;
    logic signed [4:0] pulse_count_reg;
    logic signed [4:0] pulse_count_next;

    logic              changed;
    logic [3:0]        thr_eff;
    quad_delta_t       delta;
    logic signed [5:0] sum_s;
    logic signed [5:0] thr_s;
    logic signed [5:0] neg_thr_s;
    logic              hit_dn;
    logic              hit_up;

    always_comb
    begin
        changed   = (phase != prev_phase_reg);
        thr_eff   = (step_threshold == 4'd0) ? 4'd1 : step_threshold;
        delta     = quad_delta({prev_phase_reg, phase});
        sum_s     = $signed({pulse_count_reg[4], pulse_count_reg})
                  + $signed({{4{delta[1]}}, delta});
        thr_s     = $signed({2'b00, thr_eff});
        neg_thr_s = -thr_s;
        hit_dn    = changed && (sum_s >= thr_s);
        hit_up    = changed && !hit_dn && (sum_s <= neg_thr_s);
        res.hit   = hit_dn | hit_up;
        res.up    = hit_up;

        prev_phase_next  = phase;
        pulse_count_next = pulse_count_reg;
        if (changed)
        begin
            pulse_count_next = (hit_dn | hit_up) ? 5'sd0 : sum_s[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_phase_reg  <= PHASE_RST;
            pulse_count_reg <= 5'sd0;
        end
        else if (accept)
        begin
            prev_phase_reg  <= prev_phase_next;
            pulse_count_reg <= pulse_count_next;
        end
    end

    // A volume event always leaves the count cleared.
    a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.hit |=> pulse_count_reg == 5'sd0)
        else $error("pulse count not cleared after volume event");

endmodule
`default_nettype wire

FILE: rtl/qbed_lane.sv
// One button lane: falling-edge detect and gated level update.
`default_nettype none
module qbed_lane (
    input  wire logic cur,
    input  wire logic old,
    input  wire logic open,
    output logic      fall,
    output logic      next_bit
);
    // Pressed now, released before.
    assign fall     = old & ~cur;
    // Take the new level only while the scan still reaches this lane.
    assign next_bit = open ? cur : old;
endmodule
`default_nettype wire

FILE: rtl/qbed_merge.sv
// Priority merge of lane edges: lowest button wins and closes later lanes.
`default_nettype none
module qbed_merge (
    input  wire logic [qbed_pkg::NUM_LANES-1:0] fall,
    input  wire logic                           scan_en,
    output logic [qbed_pkg::NUM_LANES-1:0]      open,
    output qbed_pkg::btn_pick_t                 pick
);
    import qbed_pkg::*;

    logic seen;

    always_comb
    begin
        seen      = 1'b0;
        pick      = '0;
        pick.code = EV_NONE;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            open[i] = scan_en & ~seen;
            if (open[i] && fall[i])
            begin
                pick.found = 1'b1;
                pick.code  = event_code_t'(i + 1);
            end
            seen = seen | fall[i];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/quadrature_and_button_event_decoder_unit.sv
// Top level of the quadrature encoder and button event decoder.
// Each input word is one poll sample: the two encoder phases, eight active-low
// button levels and a free-running millisecond time. Every accepted word gives
// exactly one output word carrying event_code: 0 none, 1..8 button 0..7
// pressed, 9 volume down, 10 volume up. A change of the phase pair is looked
// up in the quadrature table and added to a signed pulse count; reaching
// +step_threshold gives volume down, -step_threshold volume up, the count
// clears and the buttons are not looked at for that sample. Otherwise, once
// (now_ms - last press time) mod 2^32 exceeds debounce_ms, the eight button
// lanes check for falling edges in parallel and a merge stage picks the lowest
// one, restarting the debounce window; buttons above it keep their old levels.
// Throughput is one word per clock unless stalled: all decoding of a sample
// happens in the cycle it is accepted, limited by the 32-bit time subtract and
// compare, and the result sits in an output register. A new word is taken
// while the output register is empty or being drained, so in_stall rises only
// when out_stall holds a finished word. Registers (APB, 32-bit data, pready
// always high): 0x0 step_threshold[3:0] (reset 4, zero acts as one), 0x4
// debounce_ms[7:0] (reset 20). Write them only while no word is in flight.
`default_nettype none
module quadrature_and_button_event_decoder_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // APB configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // Sample input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          phase_a,
    input  wire logic                          phase_b,
    input  wire logic [qbed_pkg::BTN_BITS-1:0] button_levels,
    input  wire logic [31:0]                   now_ms,
    // Event output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output qbed_pkg::event_code_t              event_code
);
    import qbed_pkg::*;

    // Configuration registers
    logic [3:0]          step_threshold_reg;
    logic [7:0]          debounce_ms_reg;

    // Decoder state
    logic [31:0]         last_press_ms_reg;
    logic [31:0]         last_press_ms_next;
    logic [BTN_BITS-1:0] button_prev_reg;
    logic [BTN_BITS-1:0] button_prev_next;

    // Output register
    logic                out_valid_reg;
    logic                out_valid_next;
    event_code_t         event_code_reg;
    event_code_t         event_code_next;

    logic                accept;
    logic                cfg_write;
    quad_res_t           quad_res;
    logic [31:0]         elapsed;
    logic                time_ok;
    logic                scan_en;
    logic [NUM_LANES-1:0] lane_fall;
    logic [NUM_LANES-1:0] lane_open;
    btn_pick_t           pick;

    // Handshakes: hold input only while a finished word is blocked downstream.
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        case (paddr[2])
            REG_STEP_THRESHOLD: prdata = {28'd0, step_threshold_reg};
            REG_DEBOUNCE_MS:    prdata = {24'd0, debounce_ms_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_threshold_reg <= STEP_THRESHOLD_RST;
            debounce_ms_reg    <= DEBOUNCE_MS_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_STEP_THRESHOLD: step_threshold_reg <= pwdata[3:0];
                REG_DEBOUNCE_MS:    debounce_ms_reg    <= pwdata[7:0];
                default:            ;
            endcase
        end
    end

    // Encoder path
    qbed_quad u_quad (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .phase          ({phase_a, phase_b}),
        .step_threshold (step_threshold_reg),
        .res            (quad_res)
    );

    // Debounce window: wrapping difference, strictly greater than the window.
    assign elapsed = now_ms - last_press_ms_reg;
    assign time_ok = elapsed > {24'd0, debounce_ms_reg};
    // A volume event skips the button scan entirely.
    assign scan_en = time_ok & ~quad_res.hit;

    // Button lanes; buttons beyond the scanned count never change.
    for (genvar i = 0; i < BTN_BITS; i++)
    begin : g_btn
        if (i < NUM_LANES)
        begin : g_lane
            qbed_lane u_lane (
                .cur      (button_levels[i]),
                .old      (button_prev_reg[i]),
                .open     (lane_open[i]),
                .fall     (lane_fall[i]),
                .next_bit (button_prev_next[i])
            );
        end
        else
        begin : g_idle
            assign button_prev_next[i] = button_prev_reg[i];
        end
    end

    qbed_merge u_merge (
        .fall    (lane_fall),
        .scan_en (scan_en),
        .open    (lane_open),
        .pick    (pick)
    );

    always_comb
    begin
        last_press_ms_next = pick.found ? now_ms : last_press_ms_reg;

        if (quad_res.hit)
        begin
            event_code_next = quad_res.up ? EV_VOL_UP : EV_VOL_DOWN;
        end
        else
        begin
            event_code_next = pick.code;
        end

        // Load on accept, drop once the word is taken.
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg & out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_press_ms_reg <= 32'd0;
            button_prev_reg   <= BUTTONS_RST;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                last_press_ms_reg <= last_press_ms_next;
                button_prev_reg   <= button_prev_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            event_code_reg <= event_code_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = event_code_reg;

    // Every accepted sample produces an output word in the next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted sample produced no output word");

    // A button event restarts the debounce window at the sample time.
    a_press_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pick.found |=> last_press_ms_reg == $past(now_ms))
        else $error("press time not captured");

    // A button event never comes with a volume event in the same sample.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        quad_res.hit |-> !pick.found)
        else $error("button scanned during volume event");

    // Only codes with a meaning reach the output.
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> event_code_reg <= EV_VOL_UP)
        else $error("event code out of range");

endmodule
`default_nettype wire
